>>> rtl/lasp_pkg.sv
// Shared types and constants for the ASCII scan telegram parser.
`timescale 1ns / 1ps

package lasp_pkg;

    // Frame and field limits
    localparam logic [11:0] MAX_POINTS   = 12'd2048;
    localparam logic [11:0] FIELD_MAX    = 12'd4095;
    localparam logic [7:0]  POS_RESET    = 8'd23;
    localparam logic [7:0]  BYTE_ETX     = 8'h03;

    // Record kinds
    localparam logic [2:0]  KIND_START   = 3'd0;
    localparam logic [2:0]  KIND_STEP    = 3'd1;
    localparam logic [2:0]  KIND_COUNT   = 3'd2;
    localparam logic [2:0]  KIND_RANGE   = 3'd3;
    localparam logic [2:0]  KIND_END     = 3'd4;

    // Queue geometry
    localparam int          QUEUE_DEPTH  = 4;
    localparam int          QPTR_W       = $clog2(QUEUE_DEPTH);

    // One field record
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic [10:0] index;
        logic        clipped;
    } t_rec;

    // Everything one byte causes: an optional field record, an optional frame end
    typedef struct packed {
        logic        has_rec;
        t_rec        rec;
        logic        has_end;
        logic [11:0] end_count;
    } t_entry;

endpackage

>>> rtl/lasp_front.sv
// Front part: accepts telegram bytes, tracks fields and classifies closed fields.
`timescale 1ns / 1ps

module lasp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [7:0]        i_cfg_wr_data,
    input  logic              i_valid,
    input  logic              i_full,
    input  logic [7:0]        i_byte_value,
    input  logic              i_buffer_end,
    output logic              o_stall,
    output logic              o_push,
    output lasp_pkg::t_entry  o_entry
);

    logic [7:0]  r_pos;
    logic [11:0] r_field, n_field;
    logic        r_inside, n_inside;
    logic [31:0] r_acc, n_acc;
    logic        r_hexok, n_hexok;
    logic [11:0] r_declared, n_declared;
    logic [11:0] r_samples, n_samples;

    logic        accept;
    logic        is_fc;
    logic        is_hex;
    logic [3:0]  nib;
    logic [31:0] acc_upd;
    logic        hexok_upd;
    logic        end_now;
    logic        close_now;
    logic [31:0] close_val;
    logic [12:0] f13;
    logic [12:0] p1, p2, p3;
    logic [12:0] rel;
    logic        clip;
    logic [11:0] count_val;
    logic        rec_hit;

    function automatic logic field_char(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
               (b >= "a" && b <= "z") || b == "_";
    endfunction

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;

    // Classify the byte
    always_comb begin
        is_hex = 1'b1;
        nib    = 4'd0;
        if (i_byte_value >= "0" && i_byte_value <= "9") begin
            nib = 4'(i_byte_value - 8'h30);
        end else if (i_byte_value >= "a" && i_byte_value <= "f") begin
            nib = 4'(i_byte_value - 8'h57);
        end else if (i_byte_value >= "A" && i_byte_value <= "F") begin
            nib = 4'(i_byte_value - 8'h37);
        end else begin
            is_hex = 1'b0;
        end
        is_fc = field_char(i_byte_value);
    end

    // Field bookkeeping and record selection
    always_comb begin
        n_field    = r_field;
        n_inside   = r_inside;
        n_acc      = r_acc;
        n_hexok    = r_hexok;
        n_declared = r_declared;
        n_samples  = r_samples;

        acc_upd   = r_inside ? r_acc : 32'd0;
        hexok_upd = r_inside ? r_hexok : 1'b1;
        if (hexok_upd && is_hex) begin
            acc_upd = {acc_upd[27:0], nib};
        end else begin
            hexok_upd = 1'b0;
        end

        end_now   = i_buffer_end || (!is_fc && i_byte_value == lasp_pkg::BYTE_ETX);
        close_now = is_fc ? end_now : r_inside;
        close_val = is_fc ? acc_upd : r_acc;

        f13 = {1'b0, r_field};
        p1  = {5'd0, r_pos} + 13'd1;
        p2  = {5'd0, r_pos} + 13'd2;
        p3  = {5'd0, r_pos} + 13'd3;
        rel = f13 - p3;

        clip      = close_val > {20'd0, lasp_pkg::MAX_POINTS};
        count_val = clip ? lasp_pkg::MAX_POINTS : close_val[11:0];

        rec_hit             = 1'b1;
        o_entry.rec.kind    = lasp_pkg::KIND_START;
        o_entry.rec.value   = close_val;
        o_entry.rec.index   = 11'd0;
        o_entry.rec.clipped = 1'b0;
        if (f13 == {5'd0, r_pos}) begin
            o_entry.rec.kind = lasp_pkg::KIND_START;
        end else if (f13 == p1) begin
            o_entry.rec.kind = lasp_pkg::KIND_STEP;
        end else if (f13 == p2) begin
            o_entry.rec.kind    = lasp_pkg::KIND_COUNT;
            o_entry.rec.value   = {20'd0, count_val};
            o_entry.rec.clipped = clip;
            if (close_now) begin
                n_declared = count_val;
            end
        end else if (f13 >= p3 && rel < {1'b0, r_declared}) begin
            o_entry.rec.kind  = lasp_pkg::KIND_RANGE;
            o_entry.rec.value = {16'd0, close_val[15:0]};
            o_entry.rec.index = r_samples[10:0];
            if (close_now) begin
                n_samples = r_samples + 12'd1;
            end
        end else begin
            rec_hit = 1'b0;
        end

        o_entry.has_rec   = close_now && rec_hit;
        o_entry.has_end   = end_now;
        o_entry.end_count = n_samples;

        if (end_now) begin
            n_field    = 12'd0;
            n_inside   = 1'b0;
            n_acc      = 32'd0;
            n_hexok    = 1'b1;
            n_declared = 12'd0;
            n_samples  = 12'd0;
        end else if (close_now) begin
            if (r_field < lasp_pkg::FIELD_MAX) begin
                n_field = r_field + 12'd1;
            end
            n_inside = 1'b0;
            n_acc    = 32'd0;
            n_hexok  = 1'b1;
        end else if (is_fc) begin
            n_inside = 1'b1;
            n_acc    = acc_upd;
            n_hexok  = hexok_upd;
        end

        o_push = accept && (o_entry.has_rec || o_entry.has_end);
    end

    // Hold the angle position register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= lasp_pkg::POS_RESET;
        end else if (i_cfg_wr_en) begin
            r_pos <= i_cfg_wr_data;
        end
    end

    // Advance the frame state on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field    <= 12'd0;
            r_inside   <= 1'b0;
            r_acc      <= 32'd0;
            r_hexok    <= 1'b1;
            r_declared <= 12'd0;
            r_samples  <= 12'd0;
        end else if (accept) begin
            r_field    <= n_field;
            r_inside   <= n_inside;
            r_acc      <= n_acc;
            r_hexok    <= n_hexok;
            r_declared <= n_declared;
            r_samples  <= n_samples;
        end
    end

endmodule

>>> rtl/lasp_queue.sv
// Short queue of per-byte record entries between the front and back parts.
`timescale 1ns / 1ps

module lasp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lasp_pkg::t_entry  i_entry,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_nonempty,
    output lasp_pkg::t_entry  o_head
);

    lasp_pkg::t_entry r_slot [lasp_pkg::QUEUE_DEPTH];
    logic [lasp_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [lasp_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [lasp_pkg::QPTR_W:0]   r_count;

    logic do_pop;

    assign o_full     = r_count == (lasp_pkg::QPTR_W + 1)'(lasp_pkg::QUEUE_DEPTH);
    assign o_nonempty = r_count != '0;
    assign o_head     = r_slot[r_rd_ptr];
    assign do_pop     = i_pop && o_nonempty;

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/lasp_back.sv
// Back part: unpacks queue entries into single records behind an output register.
`timescale 1ns / 1ps

module lasp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_nonempty,
    input  lasp_pkg::t_entry  i_head,
    output logic              o_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [2:0]        o_record_kind,
    output logic [31:0]       o_record_value,
    output logic [10:0]       o_point_index,
    output logic              o_count_clipped,
    output logic              o_last_of_run
);

    logic        r_valid;
    logic        r_phase, n_phase;
    lasp_pkg::t_rec r_rec, n_rec;
    logic        r_last, n_last;
    logic        load;

    assign o_valid         = r_valid;
    assign o_record_kind   = r_rec.kind;
    assign o_record_value  = r_rec.value;
    assign o_point_index   = r_rec.index;
    assign o_count_clipped = r_rec.clipped;
    assign o_last_of_run   = r_last;

    assign load = !r_valid || !i_stall;

    // Pick the next record from the head entry
    always_comb begin
        n_phase = r_phase;
        n_rec   = r_rec;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (load && i_nonempty) begin
            if (!r_phase && i_head.has_rec) begin
                n_rec  = i_head.rec;
                n_last = !i_head.has_end;
                if (i_head.has_end) begin
                    n_phase = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end else begin
                n_rec.kind    = lasp_pkg::KIND_END;
                n_rec.value   = {20'd0, i_head.end_count};
                n_rec.index   = 11'd0;
                n_rec.clipped = 1'b0;
                n_last        = 1'b1;
                n_phase       = 1'b0;
                o_pop         = 1'b1;
            end
        end
    end

    // Hold the output record until transferred
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec  <= n_rec;
            r_last <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (load) begin
                r_valid <= i_nonempty;
            end
        end
    end

endmodule

>>> rtl/lidar_ascii_scan_telegram_parser_top.sv
// Top level of the ASCII scan telegram parser.
`timescale 1ns / 1ps

// Takes one telegram byte per cycle and reports the start angle, angular step,
// point count (saturated at MAX_POINTS) and range samples of the field at the
// configured position and those after it, followed by a frame-end record with
// the number of samples seen. A byte is taken every cycle while the four-entry
// record queue has room; the output side moves one record per cycle while
// i_stall is low, so a byte that closes a field and ends the frame gives the
// field record and then the frame-end record. A byte's first record is written
// to a queue slot, then to the output register, which presents it.
// Write the angle position register only while the block is idle.

module lidar_ascii_scan_telegram_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_buffer_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_record_kind,
    output logic [31:0] o_record_value,
    output logic [10:0] o_point_index,
    output logic        o_count_clipped,
    output logic        o_last_of_run
);

    logic             push;
    logic             pop;
    logic             full;
    logic             nonempty;
    lasp_pkg::t_entry entry;
    lasp_pkg::t_entry head;

    lasp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .i_full        (full),
        .i_byte_value  (i_byte_value),
        .i_buffer_end  (i_buffer_end),
        .o_stall       (o_stall),
        .o_push        (push),
        .o_entry       (entry)
    );

    lasp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (entry),
        .i_pop      (pop),
        .o_full     (full),
        .o_nonempty (nonempty),
        .o_head     (head)
    );

    lasp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_nonempty      (nonempty),
        .i_head          (head),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_record_kind   (o_record_kind),
        .o_record_value  (o_record_value),
        .o_point_index   (o_point_index),
        .o_count_clipped (o_count_clipped),
        .o_last_of_run   (o_last_of_run)
    );

endmodule
